[design/triangle_rasterizer_zbuffer_macros.svh]
// Assertion macros used by the rasterizer back end.
`ifndef TRIANGLE_RASTERIZER_ZBUFFER_MACROS_SVH
`define TRIANGLE_RASTERIZER_ZBUFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define TRZ_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TRZ_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TRZ_ASSERT_IMPL(label, clk, rst, prop, msg)
`define TRZ_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[design/trz_pkg.sv]
// Package with the shared types, constants and codes of the rasterizer.
`timescale 1ns / 1ps
package trz_pkg;
  localparam int unsigned MaxWidthDefault  = 128;
  localparam int unsigned MaxHeightDefault = 128;
  localparam logic [7:0]  FrameResetValue  = 8'd128;
  localparam int unsigned CfgIndexWidth    = 1;
  localparam logic [CfgIndexWidth-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgFrameHeight = 1'b1;
  localparam logic KindVertex = 1'b0;
  localparam logic KindRead   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [15:0]       vert_depth;
    logic [7:0]        vert_red;
    logic [7:0]        vert_green;
    logic [7:0]        vert_blue;
    logic [7:0]        vert_alpha;
    logic [6:0]        read_col;
    logic [6:0]        read_row;
  } request_t;

  typedef struct packed {
    logic        result_kind;
    logic [14:0] fragments_written;
    logic [15:0] pixel_depth;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [7:0]  pixel_alpha;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        z;
    logic [31:0]        rgba;
  } vertex_t;

  // Command from front to back.
  typedef struct packed {
    logic        is_read;
    logic [6:0]  col;
    logic [6:0]  row;
    vertex_t [2:0] vtx;
  } cmd_t;
endpackage

[design/trz_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module trz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[design/trz_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module trz_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [35:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [6:0]  cnt;
  logic        busy;
  logic [63:0] rem;
  logic [64:0] trial;
  always_comb begin
    trial = {1'b0, rem[62:0], quotient[63]} - {29'd0, divisor};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 7'd64;
        rem      <= 64'd0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[64] || rem[63]) begin
          rem      <= trial[63:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem      <= {rem[62:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[design/trz_front.sv]
// Front end: collects vertices and issues draw or read commands.
`timescale 1ns / 1ps
module trz_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  trz_pkg::request_t req,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output trz_pkg::cmd_t     cmd
);
  import trz_pkg::*;
  // Two-entry command queue.
  cmd_t        q [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  vertex_t [2:0] vtx;
  logic [1:0]  loaded;
  logic        do_push, do_pop, emit;
  vertex_t     nv;
  cmd_t        ncmd;

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];
  assign emit      = do_push && (req.kind == KindRead || loaded == 2'd2);

  always_comb begin
    nv.x = req.vert_x;
    nv.y = req.vert_y;
    nv.z = req.vert_depth;
    nv.rgba = {req.vert_red, req.vert_green, req.vert_blue, req.vert_alpha};
    ncmd.is_read = (req.kind == KindRead);
    ncmd.col = req.read_col;
    ncmd.row = req.read_row;
    ncmd.vtx = vtx;
    ncmd.vtx[2] = nv;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q[wr_ptr] <= ncmd;
    end
    if (do_push && req.kind == KindVertex) begin
      vtx[loaded] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      loaded <= 2'd0;
    end else begin
      if (emit) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, emit} - {1'b0, do_pop};
      if (do_push && req.kind == KindVertex) begin
        loaded <= (loaded == 2'd2) ? 2'd0 : loaded + 2'd1;
      end
    end
  end
endmodule

[design/trz_back.sv]
// Back end: clears the stores, rasterizes triangles and serves reads.
`timescale 1ns / 1ps
`include "triangle_rasterizer_zbuffer_macros.svh"
module trz_back #(
  parameter int unsigned MaxWidth  = trz_pkg::MaxWidthDefault,
  parameter int unsigned MaxHeight = trz_pkg::MaxHeightDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       frame_width,
  input  logic [7:0]       frame_height,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  trz_pkg::cmd_t    cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output trz_pkg::result_t res
);
  import trz_pkg::*;
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);
  localparam int unsigned AW = CW + RW;
  localparam int unsigned Depth = MaxWidth * MaxHeight;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001, S_IDLE  = 12'b000000000010,
    S_SETUP = 12'b000000000100, S_AREA  = 12'b000000001000,
    S_EDGE  = 12'b000000010000, S_WMUL  = 12'b000000100000,
    S_DIV   = 12'b000001000000, S_WAIT  = 12'b000010000000,
    S_WRITE = 12'b000100000000, S_NEXT  = 12'b001000000000,
    S_RDATA = 12'b010000000000, S_DONE  = 12'b100000000000
  } state_t;
  state_t state;

  logic [AW-1:0]  addr;
  logic           we;
  logic [15:0]    zw, zr;
  logic [31:0]    cw, cr;
  trz_ram #(.Width(16), .Depth(Depth)) u_zram (
    .clk(clk), .we(we), .addr(addr), .wdata(zw), .rdata(zr));
  trz_ram #(.Width(32), .Depth(Depth)) u_cram (
    .clk(clk), .we(we), .addr(addr), .wdata(cw), .rdata(cr));

  vertex_t [2:0] v;
  logic signed [17:0] minx, maxx, miny, maxy;
  logic [10:0] c0, c1, r0, r1, col, row, wlim, hlim;
  logic signed [35:0] area;
  logic [35:0]  ua;
  logic         neg;
  logic signed [35:0] e [3];
  logic [35:0]  wt [3];
  logic [2:0]   kidx;
  logic [51:0]  acc;
  logic [15:0]  zq;
  logic [7:0]   cq [4];
  logic [14:0]  count;
  logic [AW:0]  clr;
  logic         dstart, ddone;
  logic [63:0]  dq;
  logic         rd_oob;
  logic         rd_pending;

  trz_div u_div (.clk(clk), .rst(rst), .start(dstart), .dividend({12'd0, acc}),
    .divisor(ua), .done(ddone), .quotient(dq));

  // Edge function of a->b at point (px,py), one multiplier pair.
  function automatic logic signed [35:0] edgef(input vertex_t a, input vertex_t b,
      input logic signed [17:0] px, input logic signed [17:0] py);
    logic signed [17:0] dx, dy, qx, qy;
    begin
      dx = 18'(b.x) - 18'(a.x);
      dy = 18'(b.y) - 18'(a.y);
      qx = px - 18'(a.x);
      qy = py - 18'(a.y);
      edgef = 36'(dx * qy) - 36'(dy * qx);
    end
  endfunction

  logic signed [17:0] px, py;
  assign px = $signed({3'd0, col, 4'd8});
  assign py = $signed({3'd0, row, 4'd8});
  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign wlim = (frame_width == 8'd0) ? 11'd1 :
                ({3'd0, frame_width} > 11'(MaxWidth)) ? 11'(MaxWidth) : {3'd0, frame_width};
  assign hlim = (frame_height == 8'd0) ? 11'd1 :
                ({3'd0, frame_height} > 11'(MaxHeight)) ? 11'(MaxHeight) : {3'd0, frame_height};

  // Multiply-accumulate operands: weight k and channel ch of vertex k.
  logic [15:0] opv;
  logic [35:0] opw;
  logic [1:0]  kv;
  logic [2:0]  ch;
  assign kv = kidx[1:0];
  always_comb begin
    opw = wt[kv == 2'd3 ? 2'd0 : kv];
    case (ch)
      3'd0:    opv = v[kv == 2'd3 ? 2'd0 : kv].z;
      3'd1:    opv = {8'd0, v[kv == 2'd3 ? 2'd0 : kv].rgba[31:24]};
      3'd2:    opv = {8'd0, v[kv == 2'd3 ? 2'd0 : kv].rgba[23:16]};
      3'd3:    opv = {8'd0, v[kv == 2'd3 ? 2'd0 : kv].rgba[15:8]};
      default: opv = {8'd0, v[kv == 2'd3 ? 2'd0 : kv].rgba[7:0]};
    endcase
  end

  always_comb begin
    we = 1'b0;
    zw = 16'd0;
    cw = 32'd0;
    addr = AW'({row[RW-1:0], col[CW-1:0]});
    if (state == S_CLEAR) begin
      we = 1'b1;
      addr = clr[AW-1:0];
    end else if (state == S_WRITE) begin
      we = 1'b1;
      zw = zq;
      cw = {cq[0], cq[1], cq[2], cq[3]};
    end
  end

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            v <= cmd.vtx;
            if (cmd.is_read) begin
              rd_oob <= ({4'd0, cmd.col} >= 11'(MaxWidth)) ||
                        ({4'd0, cmd.row} >= 11'(MaxHeight));
              col <= {4'd0, cmd.col};
              row <= {4'd0, cmd.row};
              state <= S_RDATA;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_RDATA: begin
          // RAM read data arrives in the next cycle; wait in S_DONE path.
          state <= S_DONE;
          count <= 15'd0;
        end
        S_SETUP: begin
          minx <= (v[0].x < v[1].x) ? ((v[0].x < v[2].x) ? 18'(v[0].x) : 18'(v[2].x))
                                    : ((v[1].x < v[2].x) ? 18'(v[1].x) : 18'(v[2].x));
          maxx <= (v[0].x > v[1].x) ? ((v[0].x > v[2].x) ? 18'(v[0].x) : 18'(v[2].x))
                                    : ((v[1].x > v[2].x) ? 18'(v[1].x) : 18'(v[2].x));
          miny <= (v[0].y < v[1].y) ? ((v[0].y < v[2].y) ? 18'(v[0].y) : 18'(v[2].y))
                                    : ((v[1].y < v[2].y) ? 18'(v[1].y) : 18'(v[2].y));
          maxy <= (v[0].y > v[1].y) ? ((v[0].y > v[2].y) ? 18'(v[0].y) : 18'(v[2].y))
                                    : ((v[1].y > v[2].y) ? 18'(v[1].y) : 18'(v[2].y));
          area  <= edgef(v[0], v[1], 18'(v[2].x), 18'(v[2].y));
          count <= 15'd0;
          state <= S_AREA;
        end
        S_AREA: begin
          c0 <= minx[17] ? 11'd0 : 11'(minx[15:4]);
          r0 <= miny[17] ? 11'd0 : 11'(miny[15:4]);
          c1 <= (11'(maxx[15:4]) > wlim - 11'd1) ? wlim - 11'd1 : 11'(maxx[15:4]);
          r1 <= (11'(maxy[15:4]) > hlim - 11'd1) ? hlim - 11'd1 : 11'(maxy[15:4]);
          col <= minx[17] ? 11'd0 : 11'(minx[15:4]);
          row <= miny[17] ? 11'd0 : 11'(miny[15:4]);
          neg <= area[35];
          ua  <= area[35] ? 36'(-area) : 36'(area);
          if (maxx[17] || maxy[17] || area == 36'sd0) state <= S_DONE;
          else state <= S_NEXT;
        end
        S_NEXT: begin
          // Box bounds check, then evaluate edges at the current pixel.
          if (c0 > c1 || r0 > r1 || row > r1) begin
            state <= S_DONE;
          end else begin
            e[0] <= edgef(v[1], v[2], px, py);
            e[1] <= edgef(v[2], v[0], px, py);
            e[2] <= edgef(v[0], v[1], px, py);
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if ((!e[0][35] && !e[1][35] && !e[2][35]) ||
              ((e[0][35] || e[0] == 0) && (e[1][35] || e[1] == 0) &&
               (e[2][35] || e[2] == 0))) begin
            for (int k = 0; k < 3; k++) wt[k] <= neg ? 36'(-e[k]) : 36'(e[k]);
            kidx <= 3'd0;
            ch   <= 3'd0;
            acc  <= 52'd0;
            state <= S_WMUL;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WMUL: begin
          acc  <= acc + 52'(opw * opv);
          kidx <= kidx + 3'd1;
          if (kidx == 3'd2) begin
            dstart <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            if (ch == 3'd0) begin
              zq <= (dq > 64'hFFFF) ? 16'hFFFF : dq[15:0];
              if (zr != 16'd0 && ((dq > 64'hFFFF ? 16'hFFFF : dq[15:0]) >= zr)) begin
                state <= S_WAIT;
              end else begin
                ch <= 3'd1; kidx <= 3'd0; acc <= 52'd0; state <= S_WMUL;
              end
            end else begin
              cq[ch[1:0] - 2'd1] <= (dq > 64'd255) ? 8'hFF : dq[7:0];
              if (ch == 3'd4) state <= S_WRITE;
              else begin
                ch <= ch + 3'd1; kidx <= 3'd0; acc <= 52'd0; state <= S_WMUL;
              end
            end
          end
        end
        S_WRITE: begin
          if (count != 15'h7FFF) count <= count + 15'd1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (col >= c1) begin
            col <= c0;
            row <= row + 11'd1;
          end else begin
            col <= col + 11'd1;
          end
          state <= S_NEXT;
        end
        S_DONE: begin
          if (!res_valid) begin
            res.result_kind       <= rd_pending;
            res.fragments_written <= rd_pending ? 15'd0 : count;
            res.pixel_depth <= (rd_pending && !rd_oob) ? zr : 16'd0;
            res.pixel_red   <= (rd_pending && !rd_oob) ? cr[31:24] : 8'd0;
            res.pixel_green <= (rd_pending && !rd_oob) ? cr[23:16] : 8'd0;
            res.pixel_blue  <= (rd_pending && !rd_oob) ? cr[15:8] : 8'd0;
            res.pixel_alpha <= (rd_pending && !rd_oob) ? cr[7:0] : 8'd0;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pending <= 1'b0;
    else if (state == S_IDLE && cmd_valid && cmd_ready) rd_pending <= cmd.is_read;
  end

  `TRZ_ASSERT_NEVER(a_no_write_idle, clk, rst, we && state == S_IDLE, "write while idle")
  `TRZ_ASSERT_IMPL(a_ready_idle, clk, rst, cmd_ready |-> state == S_IDLE, "ready off idle")
  `TRZ_ASSERT_IMPL(a_res_hold, clk, rst, (res_valid && !res_ready) |=> res_valid, "result lost")
endmodule

[design/triangle_rasterizer_zbuffer.sv]
// Top level of the triangle rasterizer with depth buffer.
`timescale 1ns / 1ps
//  Channel   Handshake        Payload
//  request   push / full      req  (kind, vertex or read address)
//  result    pop / empty      rsp  (fragment count or pixel)
//  config    cfg_we           cfg_index, cfg_data
//
// Vertex requests are latched in the front end; a read passes S_RDATA and S_DONE in the back end.
// A triangle passes S_SETUP and S_AREA, then S_NEXT, S_EDGE and S_WAIT for each pixel of its
// clamped box, and S_DONE to report. A covered pixel adds three multiply steps and a divide
// for depth and, when it wins the depth test, three multiply steps and a divide per color
// channel plus a write in S_WRITE. After reset a clearing pass writes every store entry while
// no request reaches the back end. A full result register stalls the back end.
module triangle_rasterizer_zbuffer #(
  parameter int unsigned MAX_WIDTH  = trz_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = trz_pkg::MaxHeightDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  trz_pkg::request_t               req,
  output logic                            empty,
  input  logic                            pop,
  output trz_pkg::result_t                rsp,
  input  logic                            cfg_we,
  input  logic [trz_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import trz_pkg::*;
  logic       cmd_valid, cmd_ready, res_valid;
  cmd_t       cmd;
  logic [7:0] frame_width, frame_height;

  // Configuration registers, to be written only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameResetValue;
      frame_height <= FrameResetValue;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgFrameWidth:  frame_width  <= cfg_data;
        CfgFrameHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  trz_front u_front (.clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  trz_back #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .frame_width(frame_width), .frame_height(frame_height),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(pop), .res(rsp));

  assign empty = !res_valid;
endmodule

[tb/tb_triangle_rasterizer_zbuffer.sv]
// Self-checking testbench for the triangle rasterizer with depth buffer.
`timescale 1ns / 1ps
module tb_triangle_rasterizer_zbuffer;
  import trz_pkg::*;

  localparam int StoreW = 128;
  localparam int StoreH = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  request_t req = '0;
  logic empty;
  logic pop = 1'b0;
  result_t rsp;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CfgFrameWidth;
  logic [7:0] cfg_data = '0;

  triangle_rasterizer_zbuffer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Our own copy of the block's state: frame registers, the vertex latch and
  // both pixel stores, laid out as row * StoreW + col.
  logic [7:0] frame_w = FrameResetValue;
  logic [7:0] frame_h = FrameResetValue;
  longint vx[3], vy[3], vz[3];
  longint vcol[3][4];
  int loaded = 0;
  logic [15:0] depth_buf [StoreW*StoreH];
  logic [31:0] colour_buf [StoreW*StoreH];

  result_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  int hold_ticket = 0;

  function automatic longint edge_fn(int a, int b, longint px, longint py);
    return (vx[b] - vx[a]) * (py - vy[a]) - (vy[b] - vy[a]) * (px - vx[a]);
  endfunction

  function automatic longint clamp_dim(logic [7:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Walks the clamped bounding box, applies the depth test and updates the
  // stores; returns the number of fragments written.
  function automatic logic [14:0] rasterize();
    longint w, h, minx, maxx, miny, maxy, c0, c1, r0, r1, area, ua;
    longint e[3], wt[3];
    longint zs, z, s, count;
    int idx;
    bit neg, pos, ngt;
    logic [31:0] rgba;
    w = clamp_dim(frame_w, StoreW);
    h = clamp_dim(frame_h, StoreH);
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0];
    count = 0;
    for (int k = 1; k < 3; k++) begin
      if (vx[k] < minx) minx = vx[k];
      if (vx[k] > maxx) maxx = vx[k];
      if (vy[k] < miny) miny = vy[k];
      if (vy[k] > maxy) maxy = vy[k];
    end
    if (maxx < 0 || maxy < 0) return '0;
    if (minx < 0) minx = 0;
    if (miny < 0) miny = 0;
    c0 = minx >>> 4; c1 = maxx >>> 4;
    r0 = miny >>> 4; r1 = maxy >>> 4;
    if (c1 > w - 1) c1 = w - 1;
    if (r1 > h - 1) r1 = h - 1;
    if (c0 > c1 || r0 > r1) return '0;
    area = edge_fn(0, 1, vx[2], vy[2]);
    if (area == 0) return '0;
    neg = area < 0;
    ua = neg ? -area : area;
    for (longint r = r0; r <= r1; r++) begin
      for (longint c = c0; c <= c1; c++) begin
        e[0] = edge_fn(1, 2, c * 16 + 8, r * 16 + 8);
        e[1] = edge_fn(2, 0, c * 16 + 8, r * 16 + 8);
        e[2] = edge_fn(0, 1, c * 16 + 8, r * 16 + 8);
        pos = e[0] >= 0 && e[1] >= 0 && e[2] >= 0;
        ngt = e[0] <= 0 && e[1] <= 0 && e[2] <= 0;
        if (!pos && !ngt) continue;
        zs = 0;
        for (int k = 0; k < 3; k++) begin
          wt[k] = neg ? -e[k] : e[k];
          zs += wt[k] * vz[k];
        end
        z = zs / ua;
        if (z > 65535) z = 65535;
        idx = int'(r) * StoreW + int'(c);
        // An empty pixel (depth 0) always takes the fragment; otherwise only
        // a strictly nearer one wins.
        if (depth_buf[idx] != 0 && z >= depth_buf[idx]) continue;
        depth_buf[idx] = z[15:0];
        for (int ch = 0; ch < 4; ch++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s += wt[k] * vcol[k][ch];
          s = s / ua;
          if (s > 255) s = 255;
          rgba[31 - 8*ch -: 8] = s[7:0];
        end
        colour_buf[idx] = rgba;
        if (count < 32767) count++;
      end
    end
    return count[14:0];
  endfunction

  // Updates the predicted state for one accepted request and queues the
  // result it should produce, if any.
  task automatic predict_request(request_t r);
    result_t res;
    int idx;
    res = '0;
    if (r.kind == KindRead) begin
      idx = int'(r.read_row) * StoreW + int'(r.read_col);
      res.result_kind = KindRead;
      res.pixel_depth = depth_buf[idx];
      {res.pixel_red, res.pixel_green, res.pixel_blue, res.pixel_alpha} = colour_buf[idx];
      pending_results = {pending_results, res};
    end else begin
      vx[loaded] = r.vert_x;
      vy[loaded] = r.vert_y;
      vz[loaded] = r.vert_depth;
      vcol[loaded][0] = r.vert_red;
      vcol[loaded][1] = r.vert_green;
      vcol[loaded][2] = r.vert_blue;
      vcol[loaded][3] = r.vert_alpha;
      if (loaded < 2) begin
        loaded++;
      end else begin
        loaded = 0;
        res.result_kind = KindVertex;
        res.fragments_written = rasterize();
        pending_results = {pending_results, res};
      end
    end
  endtask

  // Offers one request until accepted; the sender works in random bursts.
  task automatic send_request(request_t r);
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(r);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_vertex(int x, int y, int z, logic [31:0] rgba);
    request_t r;
    r = '0;
    r.kind = KindVertex;
    r.vert_x = x[15:0];
    r.vert_y = y[15:0];
    r.vert_depth = z[15:0];
    {r.vert_red, r.vert_green, r.vert_blue, r.vert_alpha} = rgba;
    r.read_col = $urandom;
    r.read_row = $urandom;
    send_request(r);
  endtask

  task automatic send_read(int col, int row);
    request_t r;
    r = '0;
    r.kind = KindRead;
    r.vert_x = $urandom;
    r.vert_y = $urandom;
    r.read_col = col[6:0];
    r.read_row = row[6:0];
    send_request(r);
  endtask

  task automatic send_triangle(int x0, int y0, int x1, int y1, int x2, int y2, int z);
    send_vertex(x0, y0, z, $urandom);
    send_vertex(x1, y1, z + 100, $urandom);
    send_vertex(x2, y2, z + 200, $urandom);
  endtask

  // Lets everything drain so the frame registers can change safely.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_config(logic [CfgIndexWidth-1:0] index, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CfgFrameWidth) frame_w = value;
    else frame_h = value;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [7:0] w, logic [7:0] h);
    wait_drained();
    write_config(CfgFrameWidth, w);
    write_config(CfgFrameHeight, h);
  endtask

  // Reads of a freshly cleared store, at three corners and one inner pixel.
  task automatic test_cleared_store();
    send_read(0, 0);
    send_read(127, 127);
    send_read(127, 0);
    send_read(64, 33);
  endtask

  // Both windings, a degenerate triangle, off-screen boxes, a nearer and a
  // farther overdraw, and a triangle whose depth computes to zero.
  task automatic test_directed_triangles();
    send_triangle(16, 16, 80, 20, 30, 70, 5000);
    send_triangle(16, 16, 30, 70, 80, 20, 3000);
    send_triangle(16, 16, 80, 20, 30, 70, 9000);
    send_read(2, 2);
    send_triangle(40, 40, 40, 40, 90, 90, 100);
    send_triangle(-200, 10, -20, 60, -100, 90, 100);
    send_triangle(10, -200, 60, -20, 90, -100, 100);
    send_triangle(2100, 40, 2200, 60, 2150, 90, 100);
    send_vertex(160, 160, 0, 32'hFFFFFFFF);
    send_vertex(230, 160, 0, 32'h00000000);
    send_vertex(190, 230, 0, 32'hFF00FF00);
    send_read(11, 11);
  endtask

  // Frame register extremes, including zero and values beyond the store,
  // with vertices at the ends of the coordinate range.
  task automatic test_frame_extremes();
    set_frame(8'd1, 8'd1);
    send_vertex(-32768, -32768, 65535, 32'hFFFFFFFF);
    send_vertex(32767, -32768, 65535, 32'hFFFFFFFF);
    send_vertex(-32768, 32767, 65535, 32'hFFFFFFFF);
    send_read(0, 0);
    set_frame(8'd0, 8'd255);
    send_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 1);
    send_read(0, 127);
    set_frame(8'd255, 8'd0);
    send_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 0);
    send_read(127, 0);
  endtask

  // The receiver holds off for a long stretch while reads keep coming, so the
  // block fills up and deasserts acceptance.
  task automatic test_backpressure();
    wait_drained();
    hold_ticket++;
    repeat (40) send_read($urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  // Mostly well formed small triangles near the frame, mixed with reads and
  // the odd degenerate or wildly placed vertex.
  task automatic test_random(logic [7:0] w, logic [7:0] h, int items);
    int cw, ch, bx, by, span, nv, x, y, px, py;
    cw = clamp_dim(w, StoreW);
    ch = clamp_dim(h, StoreH);
    set_frame(w, h);
    nv = 0; bx = 0; by = 0; span = 48; px = 0; py = 0;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 1) == 1)
          send_read($urandom_range(0, cw - 1), $urandom_range(0, ch - 1));
        else
          send_read($urandom_range(0, 127), $urandom_range(0, 127));
        continue;
      end
      if (nv % 3 == 0) begin
        bx = $urandom_range(0, cw - 1);
        by = $urandom_range(0, ch - 1);
        span = ($urandom_range(0, 99) < 5) ? 160 : 48;
      end
      x = bx * 16 + $urandom_range(0, span) - 16;
      y = by * 16 + $urandom_range(0, span) - 16;
      if ($urandom_range(0, 99) < 5) begin
        x = px;
        y = py;
      end else if (cw * ch <= 64 && $urandom_range(0, 99) < 10) begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
      end
      send_vertex(x, y, $urandom_range(0, 65535), $urandom);
      px = x; py = y;
      nv++;
    end
  endtask

  // Receiver: cycles through stall patterns, plus one long hold on request.
  always @(posedge clk) begin
    static int phase_cnt = 0;
    static int mode = 0;
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = 3000;
    end
    phase_cnt++;
    if (phase_cnt % 200 == 0) mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (mode == 0) begin
      pop <= 1'b1;
    end else if (mode == 1) begin
      pop <= $urandom_range(0, 1);
    end else begin
      pop <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic report_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && !empty && pop) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, rsp);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_kind", want.result_kind, rsp.result_kind);
        report_field("fragments_written", want.fragments_written, rsp.fragments_written);
        report_field("pixel_depth", want.pixel_depth, rsp.pixel_depth);
        report_field("pixel_red", want.pixel_red, rsp.pixel_red);
        report_field("pixel_green", want.pixel_green, rsp.pixel_green);
        report_field("pixel_blue", want.pixel_blue, rsp.pixel_blue);
        report_field("pixel_alpha", want.pixel_alpha, rsp.pixel_alpha);
      end
    end
  end

  initial begin
    for (int i = 0; i < StoreW * StoreH; i++) begin
      depth_buf[i] = '0;
      colour_buf[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_cleared_store();
    test_directed_triangles();
    test_frame_extremes();
    test_backpressure();
    test_random(8'd128, 8'd128, 320);
    test_random(8'd16, 8'd16, 300);
    test_random(8'd5, 8'd9, 260);
    test_random(8'd1, 8'd128, 220);
    test_random(8'd128, 8'd1, 220);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #600_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/trz_pkg.sv
design/trz_ram.sv
design/trz_div.sv
design/trz_front.sv
design/trz_back.sv
design/triangle_rasterizer_zbuffer.sv
tb/tb_triangle_rasterizer_zbuffer.sv
